// File: rtl/wf3_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wf3_pkg
// Shared types, constants and helpers of the 3x3 window filter.
// ----------------------------------------------------------------------------
package wf3_pkg;

  // Frame size limits
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int MIN_DIM    = 3;

  // Counter and index widths
  localparam int COL_W  = $clog2(MAX_WIDTH);       // column index / line store address
  localparam int WDIM_W = COL_W + 1;               // clamped width
  localparam int ROW_W  = $clog2(MAX_HEIGHT) + 1;  // row counter, holds the height itself

  // Fixed field widths
  localparam int PIX_W     = 8;
  localparam int OUT_POS_W = 10;
  localparam int CFG_DIM_W = 11;
  localparam int CFG_THR_W = 12;
  localparam int SUM_W     = 12;                   // sum of nine pixels

  // Box mean: floor(x / 9) == (x * RECIP9) >> RECIP9_SHIFT for x < 9 * 256
  localparam int RECIP9       = 7282;
  localparam int RECIP9_W     = 13;
  localparam int RECIP9_SHIFT = 16;

  // Configuration register file
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;
  typedef enum logic [1:0] {
    REG_FRAME_WIDTH    = 2'd0,
    REG_FRAME_HEIGHT   = 2'd1,
    REG_FILTER_MODE    = 2'd2,
    REG_EDGE_THRESHOLD = 2'd3
  } reg_idx_t;

  localparam logic [CFG_DIM_W-1:0] FRAME_WIDTH_RST  = CFG_DIM_W'(640);
  localparam logic [CFG_DIM_W-1:0] FRAME_HEIGHT_RST = CFG_DIM_W'(480);
  localparam logic [CFG_THR_W-1:0] EDGE_THR_RST     = CFG_THR_W'(50);

  typedef enum logic [1:0] {
    MODE_BOX     = 2'd0,
    MODE_MEDIAN  = 2'd1,
    MODE_SOBEL   = 2'd2,
    MODE_LAPLACE = 2'd3
  } mode_t;

  typedef logic [PIX_W-1:0] pix_t;
  typedef pix_t [8:0] win_t;

  typedef struct packed {
    logic [CFG_DIM_W-1:0]        frame_width;
    logic [CFG_DIM_W-1:0]        frame_height;
    mode_t                       filter_mode;
    logic signed [CFG_THR_W-1:0] edge_threshold;
  } cfg_t;

  // Per-item control carried down the pipeline
  typedef struct packed {
    logic                 a_en;    // result for (r-1, c-1)
    logic                 a_filt;  // interior: filtered, else passed through
    logic [OUT_POS_W-1:0] a_row;
    logic [OUT_POS_W-1:0] a_col;
    logic                 b_en;    // last-column result or flushed pixel
    logic [OUT_POS_W-1:0] b_row;
    logic [OUT_POS_W-1:0] b_col;
    logic                 b_fd;
    logic                 wr;      // pixel item: update line stores and window
    logic [COL_W-1:0]     addr;
    pix_t                 pixel;
  } meta_t;

  typedef struct packed {
    pix_t                 value;
    logic [OUT_POS_W-1:0] row;
    logic [OUT_POS_W-1:0] col;
    logic                 last;
    logic                 fd;
  } result_t;

  function automatic logic [WDIM_W-1:0] clamp_width(logic [CFG_DIM_W-1:0] v);
    if (32'(v) < 32'(MIN_DIM)) return WDIM_W'(MIN_DIM);
    if (32'(v) > 32'(MAX_WIDTH)) return WDIM_W'(MAX_WIDTH);
    return WDIM_W'(v);
  endfunction

  function automatic logic [ROW_W-1:0] clamp_height(logic [CFG_DIM_W-1:0] v);
    if (32'(v) < 32'(MIN_DIM)) return ROW_W'(MIN_DIM);
    if (32'(v) > 32'(MAX_HEIGHT)) return ROW_W'(MAX_HEIGHT);
    return ROW_W'(v);
  endfunction

endpackage

// File: rtl/wf3_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wf3_in_if / wf3_out_if
// Valid/ready stream channels for input pixels and output results.
// ----------------------------------------------------------------------------
interface wf3_in_if;
  logic          valid;
  logic          ready;
  logic          action;
  wf3_pkg::pix_t pixel;

  modport source (output valid, action, pixel, input ready);
  modport sink   (input valid, action, pixel, output ready);
endinterface

interface wf3_out_if;
  logic                            valid;
  logic                            ready;
  wf3_pkg::pix_t                   value;
  logic [wf3_pkg::OUT_POS_W-1:0]   out_row;
  logic [wf3_pkg::OUT_POS_W-1:0]   out_col;
  logic                            last;
  logic                            frame_done;

  modport source (output valid, value, out_row, out_col, last, frame_done, input ready);
  modport sink   (input valid, value, out_row, out_col, last, frame_done, output ready);
endinterface

// File: rtl/wf3_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wf3_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module wf3_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/wf3_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wf3_cfg
// APB register file: frame size, filter mode and edge threshold.
// ----------------------------------------------------------------------------
module wf3_cfg (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [wf3_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [wf3_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [wf3_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                               pready,
  output wf3_pkg::cfg_t                      cfg
);

  wf3_pkg::reg_idx_t idx;
  logic              wr_en;

  assign idx    = wf3_pkg::reg_idx_t'(paddr[wf3_pkg::CFG_ADDR_W-1:2]);
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.frame_width    <= wf3_pkg::FRAME_WIDTH_RST;
      cfg.frame_height   <= wf3_pkg::FRAME_HEIGHT_RST;
      cfg.filter_mode    <= wf3_pkg::MODE_BOX;
      cfg.edge_threshold <= $signed(wf3_pkg::EDGE_THR_RST);
    end else if (wr_en) begin
      unique case (idx)
        wf3_pkg::REG_FRAME_WIDTH: begin
          cfg.frame_width <= pwdata[wf3_pkg::CFG_DIM_W-1:0];
        end
        wf3_pkg::REG_FRAME_HEIGHT: begin
          cfg.frame_height <= pwdata[wf3_pkg::CFG_DIM_W-1:0];
        end
        wf3_pkg::REG_FILTER_MODE: begin
          cfg.filter_mode <= wf3_pkg::mode_t'(pwdata[1:0]);
        end
        wf3_pkg::REG_EDGE_THRESHOLD: begin
          cfg.edge_threshold <= $signed(pwdata[wf3_pkg::CFG_THR_W-1:0]);
        end
      endcase
    end
  end

  // Read mux
  always_comb begin
    unique case (idx)
      wf3_pkg::REG_FRAME_WIDTH:  prdata = wf3_pkg::CFG_DATA_W'(cfg.frame_width);
      wf3_pkg::REG_FRAME_HEIGHT: prdata = wf3_pkg::CFG_DATA_W'(cfg.frame_height);
      wf3_pkg::REG_FILTER_MODE:  prdata = wf3_pkg::CFG_DATA_W'(cfg.filter_mode);
      wf3_pkg::REG_EDGE_THRESHOLD: begin
        prdata = wf3_pkg::CFG_DATA_W'($unsigned(cfg.edge_threshold));
      end
    endcase
  end

endmodule

// File: rtl/wf3_kernel.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wf3_kernel
// Two-stage arithmetic on the 3x3 window: box mean, median of nine,
// Sobel magnitude and Laplacian threshold, selected by the filter mode.
// ----------------------------------------------------------------------------
module wf3_kernel (
  input  logic                                 clk,
  input  logic                                 en,
  input  wf3_pkg::win_t                        win,
  input  wf3_pkg::mode_t                       mode,
  input  logic signed [wf3_pkg::CFG_THR_W-1:0] thresh,
  output wf3_pkg::pix_t                        result
);

  localparam int PROD_W = wf3_pkg::SUM_W + wf3_pkg::RECIP9_W;

  function automatic wf3_pkg::pix_t min2(wf3_pkg::pix_t a, wf3_pkg::pix_t b);
    return (a < b) ? a : b;
  endfunction

  function automatic wf3_pkg::pix_t max2(wf3_pkg::pix_t a, wf3_pkg::pix_t b);
    return (a < b) ? b : a;
  endfunction

  function automatic wf3_pkg::pix_t med3(wf3_pkg::pix_t a, wf3_pkg::pix_t b,
                                         wf3_pkg::pix_t c);
    return max2(min2(a, b), min2(max2(a, b), c));
  endfunction

  function automatic logic signed [11:0] sx(wf3_pkg::pix_t p);
    return $signed({4'b0000, p});
  endfunction

  // First stage registers
  wf3_pkg::pix_t                 lo [3];
  wf3_pkg::pix_t                 mid [3];
  wf3_pkg::pix_t                 hi [3];
  logic [wf3_pkg::SUM_W-1:0]     sum;
  logic signed [11:0]            gx;
  logic signed [11:0]            gy;
  logic signed [11:0]            lap;

  wf3_pkg::pix_t                 lo_next [3];
  wf3_pkg::pix_t                 mid_next [3];
  wf3_pkg::pix_t                 hi_next [3];
  logic [wf3_pkg::SUM_W-1:0]     sum_next;
  logic [wf3_pkg::SUM_W-1:0]     nb_sum;

  // Second stage registers
  wf3_pkg::pix_t                 mean;
  wf3_pkg::pix_t                 sobel;
  wf3_pkg::pix_t                 max_lo;
  wf3_pkg::pix_t                 med_mid;
  wf3_pkg::pix_t                 min_hi;
  logic                          lap_hit;

  logic [PROD_W-1:0]             prod;
  logic [11:0]                   gx_abs;
  logic [11:0]                   gy_abs;
  logic [11:0]                   mag;

  // Sort each window row, sum, gradients
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      lo_next[k]  = min2(min2(win[3*k], win[3*k+1]), win[3*k+2]);
      hi_next[k]  = max2(max2(win[3*k], win[3*k+1]), win[3*k+2]);
      mid_next[k] = med3(win[3*k], win[3*k+1], win[3*k+2]);
    end
    sum_next = wf3_pkg::SUM_W'(win[0]) + wf3_pkg::SUM_W'(win[1]) + wf3_pkg::SUM_W'(win[2])
             + wf3_pkg::SUM_W'(win[3]) + wf3_pkg::SUM_W'(win[4]) + wf3_pkg::SUM_W'(win[5])
             + wf3_pkg::SUM_W'(win[6]) + wf3_pkg::SUM_W'(win[7]) + wf3_pkg::SUM_W'(win[8]);
    nb_sum   = sum_next - wf3_pkg::SUM_W'(win[4]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lo  <= lo_next;
      mid <= mid_next;
      hi  <= hi_next;
      sum <= sum_next;
      gx  <= sx(win[2]) + (sx(win[5]) <<< 1) + sx(win[8])
           - sx(win[0]) - (sx(win[3]) <<< 1) - sx(win[6]);
      gy  <= sx(win[6]) + (sx(win[7]) <<< 1) + sx(win[8])
           - sx(win[0]) - (sx(win[1]) <<< 1) - sx(win[2]);
      // eight neighbors minus eight times the center
      lap <= $signed(nb_sum) - $signed({1'b0, win[4], 3'b000});
    end
  end

  // Mean by reciprocal, gradient magnitude, median partial picks
  always_comb begin
    prod   = PROD_W'(sum) * PROD_W'(wf3_pkg::RECIP9);
    gx_abs = gx[11] ? 12'(-gx) : 12'(gx);
    gy_abs = gy[11] ? 12'(-gy) : 12'(gy);
    mag    = gx_abs + gy_abs;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mean    <= prod[wf3_pkg::RECIP9_SHIFT +: wf3_pkg::PIX_W];
      sobel   <= (mag > 12'd255) ? 8'hFF : mag[7:0];
      max_lo  <= max2(max2(lo[0], lo[1]), lo[2]);
      med_mid <= med3(mid[0], mid[1], mid[2]);
      min_hi  <= min2(min2(hi[0], hi[1]), hi[2]);
      lap_hit <= (lap > thresh);
    end
  end

  // Mode select
  always_comb begin
    case (mode)
      wf3_pkg::MODE_BOX:    result = mean;
      wf3_pkg::MODE_MEDIAN: result = med3(max_lo, med_mid, min_hi);
      wf3_pkg::MODE_SOBEL:  result = sobel;
      default:              result = lap_hit ? 8'hFF : 8'h00;
    endcase
  end

endmodule

// File: rtl/window_filter_3x3_multi_mode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// window_filter_3x3_multi_mode
// 3x3 sliding-window filter over a raster pixel stream, two line stores in
// RAM, four filter modes, border pass-through and end-of-frame flush.
// ----------------------------------------------------------------------------
// Path: an item passes stages 1 to 4 and the holding stage into the output
//   register; a last-column item puts a second result behind the first.
// Throughput: one item per cycle when the output is ready; a last-column
//   item with two results holds the input until the output register takes one.
// Reset: clears counters, window, pipeline valids and the output register;
//   the line stores are not cleared, configuration returns to its defaults.
// ----------------------------------------------------------------------------
module window_filter_3x3_multi_mode (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [wf3_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [wf3_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [wf3_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready,
  wf3_in_if.sink                         pix_in,
  wf3_out_if.source                      pix_out
);

  localparam int COL_W  = wf3_pkg::COL_W;
  localparam int ROW_W  = wf3_pkg::ROW_W;
  localparam int WDIM_W = wf3_pkg::WDIM_W;
  localparam int POS_W  = wf3_pkg::OUT_POS_W;

  wf3_pkg::cfg_t    cfg;
  logic [WDIM_W-1:0] w_cl;
  logic [ROW_W-1:0]  h_cl;

  // Position counters
  logic [ROW_W-1:0]  row_count, row_count_next;
  logic [COL_W-1:0]  col_count, col_count_next;

  // Pipeline
  logic              adv, acc, s1_we, out_free;
  wf3_pkg::meta_t    s0;
  logic              s1_valid, s2_valid, s3_valid, s4_valid;
  wf3_pkg::meta_t    s1, s2, s3, s4;
  wf3_pkg::pix_t     s2_va, s3_va, s4_va;
  wf3_pkg::pix_t     s2_vb, s3_vb, s4_vb;
  wf3_pkg::pix_t     rd_above, rd_two;
  wf3_pkg::win_t     window;
  wf3_pkg::pix_t     kern_value;

  // Result holding stage and output register
  logic [1:0]        f_cnt, f_cnt_load;
  wf3_pkg::result_t  f_res [2];
  wf3_pkg::result_t  res_a, res_b;
  wf3_pkg::result_t  load0, load1;
  logic              out_valid;
  wf3_pkg::result_t  out_res;

  wf3_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign w_cl = wf3_pkg::clamp_width(cfg.frame_width);
  assign h_cl = wf3_pkg::clamp_height(cfg.frame_height);

  // Accept stage: position, result plan, line store read address
  always_comb begin
    logic [ROW_W-1:0]  r1, r;
    logic [COL_W-1:0]  c1, c;
    logic [WDIM_W-1:0] c_inc;
    logic              drain;
    logic              fl_end;

    s0             = '0;
    s0.pixel       = pix_in.pixel;
    row_count_next = row_count;
    col_count_next = col_count;
    r1             = row_count;
    c1             = col_count;
    r              = row_count;
    c              = col_count;
    c_inc          = WDIM_W'(col_count) + WDIM_W'(1);
    drain          = (row_count >= h_cl);
    fl_end         = (WDIM_W'(col_count) >= w_cl);

    if (pix_in.action) begin
      // flush beat: drains the last row once the frame is complete
      s0.addr  = col_count;
      s0.b_en  = drain && !fl_end;
      s0.b_row = POS_W'(h_cl - ROW_W'(1));
      s0.b_col = POS_W'(col_count);
      s0.b_fd  = (WDIM_W'(col_count) == w_cl - WDIM_W'(1));
      if (drain) begin
        if (fl_end || c_inc >= w_cl) begin
          row_count_next = '0;
          col_count_next = '0;
        end else begin
          col_count_next = c_inc[COL_W-1:0];
        end
      end
    end else begin
      // pixel beat: wrap a stale column, restart after a complete frame
      if (fl_end) begin
        r1 = row_count + ROW_W'(1);
        c1 = '0;
      end
      if (r1 >= h_cl) begin
        r = '0;
        c = '0;
      end else begin
        r = r1;
        c = c1;
      end
      c_inc     = WDIM_W'(c) + WDIM_W'(1);
      s0.wr     = 1'b1;
      s0.addr   = c;
      s0.a_en   = (r != '0) && (c != '0);
      s0.a_filt = (r >= ROW_W'(2)) && (c >= COL_W'(2));
      s0.a_row  = POS_W'(r - ROW_W'(1));
      s0.a_col  = POS_W'(c - COL_W'(1));
      s0.b_en   = (r != '0) && (WDIM_W'(c) == w_cl - WDIM_W'(1));
      s0.b_row  = POS_W'(r - ROW_W'(1));
      s0.b_col  = POS_W'(c);
      if (c_inc >= w_cl) begin
        col_count_next = '0;
        row_count_next = r + ROW_W'(1);
      end else begin
        col_count_next = c_inc[COL_W-1:0];
        row_count_next = r;
      end
    end
  end

  // Handshake: pipeline moves when the holding stage is empty or its one result goes out
  assign out_free     = !out_valid || pix_out.ready;
  assign adv          = (f_cnt == 2'd0) || (f_cnt == 2'd1 && out_free);
  assign acc          = pix_in.valid && adv;
  assign pix_in.ready = adv;
  assign s1_we        = adv && s1_valid && s1.wr;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= '0;
      col_count <= '0;
    end else if (acc) begin
      row_count <= row_count_next;
      col_count <= col_count_next;
    end
  end

  // Line stores: read on accept, write back when the item leaves stage 1
  wf3_ram #(.WIDTH(wf3_pkg::PIX_W), .DEPTH(wf3_pkg::MAX_WIDTH)) u_line_above (
    .clk   (clk),
    .we    (s1_we),
    .waddr (s1.addr),
    .wdata (s1.pixel),
    .re    (acc),
    .raddr (s0.addr),
    .rdata (rd_above)
  );

  wf3_ram #(.WIDTH(wf3_pkg::PIX_W), .DEPTH(wf3_pkg::MAX_WIDTH)) u_line_two_above (
    .clk   (clk),
    .we    (s1_we),
    .waddr (s1.addr),
    .wdata (rd_above),
    .re    (acc),
    .raddr (s0.addr),
    .rdata (rd_two)
  );

  // Pipeline stages and window shift
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
      window   <= '0;
    end else if (adv) begin
      s1_valid <= acc;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      s4_valid <= s3_valid;
      if (s1_valid && s1.wr) begin
        window[0] <= window[1];
        window[1] <= window[2];
        window[2] <= rd_two;
        window[3] <= window[4];
        window[4] <= window[5];
        window[5] <= rd_above;
        window[6] <= window[7];
        window[7] <= window[8];
        window[8] <= s1.pixel;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1    <= s0;
      s2    <= s1;
      s2_va <= window[5];   // becomes the window center after the shift
      s2_vb <= rd_above;    // last-column or flushed pixel
      s3    <= s2;
      s3_va <= s2_va;
      s3_vb <= s2_vb;
      s4    <= s3;
      s4_va <= s3_va;
      s4_vb <= s3_vb;
    end
  end

  wf3_kernel u_kernel (
    .clk    (clk),
    .en     (adv),
    .win    (window),
    .mode   (cfg.filter_mode),
    .thresh (cfg.edge_threshold),
    .result (kern_value)
  );

  // Results of the item leaving stage 4, packed to the front
  always_comb begin
    res_a.value = s4.a_filt ? kern_value : s4_va;
    res_a.row   = s4.a_row;
    res_a.col   = s4.a_col;
    res_a.last  = !s4.b_en;
    res_a.fd    = 1'b0;
    res_b.value = s4_vb;
    res_b.row   = s4.b_row;
    res_b.col   = s4.b_col;
    res_b.last  = 1'b1;
    res_b.fd    = s4.b_fd;
    load0       = s4.a_en ? res_a : res_b;
    load1       = res_b;
    f_cnt_load  = s4_valid ? (2'({1'b0, s4.a_en}) + 2'({1'b0, s4.b_en})) : 2'd0;
  end

  // Holding stage feeds the output register one beat at a time
  always_ff @(posedge clk) begin
    if (rst) begin
      f_cnt     <= 2'd0;
      out_valid <= 1'b0;
    end else begin
      if (out_free) begin
        out_valid <= (f_cnt != 2'd0);
      end
      if (adv) begin
        f_cnt <= f_cnt_load;
      end else if (out_free && f_cnt != 2'd0) begin
        f_cnt <= f_cnt - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && f_cnt != 2'd0) begin
      out_res <= f_res[0];
    end
    if (adv) begin
      f_res[0] <= load0;
      f_res[1] <= load1;
    end else if (out_free && f_cnt != 2'd0) begin
      f_res[0] <= f_res[1];
    end
  end

  assign pix_out.valid      = out_valid;
  assign pix_out.value      = out_res.value;
  assign pix_out.out_row    = out_res.row;
  assign pix_out.out_col    = out_res.col;
  assign pix_out.last       = out_res.last;
  assign pix_out.frame_done = out_res.fd;

  // Checks
  a_no_rw_collision: assert property (@(posedge clk) disable iff (rst)
    (acc && s1_we) |-> (s0.addr != s1.addr))
    else $error("line store read and write hit the same column");

  a_fd_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (!out_res.fd || out_res.last))
    else $error("frame_done on a beat that is not last");

  a_col_in_frame: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (WDIM_W'(out_res.col) < w_cl))
    else $error("output column outside the frame");

  a_hold_bound: assert property (@(posedge clk) disable iff (rst)
    (f_cnt == 2'd2) |=> (f_cnt != 2'd0) && !s1_valid || (f_cnt != 2'd3))
    else $error("holding stage count out of range");

endmodule
